[rtl/sdfc_pkg.sv]
package sdfc_pkg;

    localparam int MAX_WIDTH  = 512;
    localparam int MAX_HEIGHT = 512;
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int ADDR_W     = COL_W + ROW_W;
    localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;

    localparam int FIELD_W = 24;
    localparam logic signed [FIELD_W-1:0] FAR_VALUE = 24'sh7FFFFF;
    localparam logic signed [FIELD_W-1:0] FIELD_MIN = 24'sh800000;

    localparam int MUL_W  = 24;
    localparam int PROD_W = 2 * MUL_W;
    localparam int SQ_W   = 50;   // dx^2 + dy^2 < 2^49
    localparam int ROOT_W = SQ_W / 2;

    typedef enum logic [1:0] {
        ACT_CLEAR = 2'd0,
        ACT_SPLAT = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        REG_WIDTH  = 2'd0,
        REG_HEIGHT = 2'd1,
        REG_RADIUS = 2'd2,
        REG_THRESH = 2'd3
    } cfg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_CX, ST_CY, ST_RW, ST_BOX, ST_DY, ST_DY2,
        ST_DX, ST_SQ, ST_SQW, ST_M1, ST_M2, ST_RD, ST_RD2, ST_FIN
    } state_t;

    typedef struct packed {
        logic                      we;
        logic [ADDR_W-1:0]         waddr;
        logic signed [FIELD_W-1:0] wdata;
        logic                      re;
        logic [ADDR_W-1:0]         raddr;
    } mem_req_t;

    typedef struct packed {
        logic            start;
        logic [SQ_W-1:0] operand;
    } sqrt_req_t;

    typedef struct packed {
        logic              done;
        logic [ROOT_W-1:0] root;
    } sqrt_rsp_t;

endpackage

[rtl/sdfc_if.sv]
interface sdfc_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic signed [15:0] fiber_x;
    logic signed [15:0] fiber_y;
    logic [15:0] fiber_weight;
    logic [8:0]  read_col;
    logic [8:0]  read_row;
    modport source (output valid, action, fiber_x, fiber_y, fiber_weight, read_col,
                    read_row, input ready);
    modport sink (input valid, action, fiber_x, fiber_y, fiber_weight, read_col,
                  read_row, output ready);
endinterface

interface sdfc_out_if;
    logic        valid;
    logic        ready;
    logic signed [23:0] cell_value;
    logic        fiber_skipped;
    modport source (output valid, cell_value, fiber_skipped, input ready);
    modport sink (input valid, cell_value, fiber_skipped, output ready);
endinterface

interface sdfc_cfg_if;
    logic        valid;
    logic        ready;
    logic [1:0]  index;
    logic [15:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/sdf_circle_splat_field.sv]
// Circle-splat distance field, 512 x 512 cells of signed Q15.8 in one RAM.
// fiber_in: one request per item (action clear / splat / read / none);
//   accepted when valid and ready are both high. ready is low while a
//   request is being worked on.
// cell_out: one result per request; cell_value holds the read cell (zero
//   for other actions), fiber_skipped flags a splat below the threshold.
//   The result sits in an output register, so the next request can be
//   taken while it waits; a stalled receiver only holds back the end of
//   the following request.
// cfg: register writes (index 0 width, 1 height, 2 radius, 3 threshold),
//   always ready, to be issued while no request is in flight.
// Work per request, input accept to result valid: a read does one RAM
//   read; none or a skipped splat goes straight to the result; clear
//   writes one cell per cycle; a splat finds centre, radius and box, then
//   runs each cell through the shared bit-serial square root, the one
//   shared 24x24 multiplier and the RAM's write and read ports.
// Reset: registers return to defaults and the RAM is swept to the far
//   value, while fiber_in.ready stays low.
module sdf_circle_splat_field
    import sdfc_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    sdfc_in_if.sink    fiber_in,
    sdfc_out_if.source cell_out,
    sdfc_cfg_if.sink   cfg
);

    state_t state_reg, state_next;

    // configuration
    logic [9:0]  width_reg, height_reg;
    logic [6:0]  radius_reg;
    logic [15:0] thresh_reg;

    // latched request
    logic [1:0]  act_reg;
    logic [15:0] fx_reg, fy_reg, w_reg;
    logic [8:0]  rcol_reg, rrow_reg;

    // splat working set
    logic [25:0]          cx_reg, cy_reg;
    logic [19:0]          rw_reg;
    logic [COL_W-1:0]     x_reg, x0_reg, x1_reg;
    logic [ROW_W-1:0]     y_reg, y1_reg;
    logic [PROD_W-1:0]    dy2_reg;
    logic signed [FIELD_W-1:0] mn_reg;
    logic [ADDR_W-1:0]    clr_cnt_reg;
    logic                 clr_item_reg;

    // pending and output results
    logic signed [FIELD_W-1:0] res_value_reg;
    logic                      res_skip_reg;
    logic                      out_valid_reg;
    logic signed [FIELD_W-1:0] out_value_reg;
    logic                      out_skip_reg;

    logic [MUL_W-1:0]  mul_a, mul_b;
    logic [PROD_W-1:0] prod;
    mem_req_t          mem_req;
    logic signed [FIELD_W-1:0] mem_rdata;
    sqrt_req_t         sq_req;
    sqrt_rsp_t         sq_rsp;

    logic        in_acc;
    logic [9:0]  wd, ht;
    logic [22:0] r16;
    logic [26:0] hi_x_sum, hi_y_sum;
    logic [10:0] hi_x, hi_y;
    logic [COL_W-1:0] box_x0, box_x1;
    logic [ROW_W-1:0] box_y0, box_y1;
    logic [25:0] xpos, ypos;
    logic [MUL_W-1:0] dx_abs, dy_abs;
    logic [17:0] dist_q8;
    logic signed [FIELD_W-1:0] cur, old;
    logic signed [FIELD_W:0]   diff;
    logic [FIELD_W:0]          diff_abs;
    logic [10:0]               h_val;
    logic [10:0]               hq;
    logic signed [FIELD_W:0]   nv;
    logic signed [FIELD_W-1:0] nv_sat;
    logic                      rd_far;
    logic                      fin_go;

    sdfc_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    sdfc_isqrt u_sqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (sq_req),
        .rsp   (sq_rsp)
    );

    sdfc_field_mem u_mem (
        .clk   (clk),
        .req   (mem_req),
        .rdata (mem_rdata)
    );

    assign in_acc         = fiber_in.valid && fiber_in.ready;
    assign fiber_in.ready = (state_reg == ST_IDLE);
    assign cfg.ready      = 1'b1;

    // sizes in use: zero acts as one, oversize acts as the maximum
    always_comb
    begin
        if (width_reg == '0)
            wd = 10'd1;
        else if (32'(width_reg) > MAX_WIDTH)
            wd = 10'(MAX_WIDTH);
        else
            wd = width_reg;
        if (height_reg == '0)
            ht = 10'd1;
        else if (32'(height_reg) > MAX_HEIGHT)
            ht = 10'(MAX_HEIGHT);
        else
            ht = height_reg;
    end

    // box bounds around the Q.16 centre, clamped to the field
    always_comb
    begin
        r16      = {radius_reg, 16'b0};
        hi_x_sum = 27'(cx_reg) + 27'(r16);
        hi_y_sum = 27'(cy_reg) + 27'(r16);
        hi_x     = hi_x_sum[26:16];
        hi_y     = hi_y_sum[26:16];
        box_x0   = (cx_reg < 26'(r16)) ? '0 : COL_W'((cx_reg - 26'(r16)) >> 16);
        box_y0   = (cy_reg < 26'(r16)) ? '0 : ROW_W'((cy_reg - 26'(r16)) >> 16);
        box_x1   = (hi_x > 11'(wd - 10'd1)) ? COL_W'(wd - 10'd1) : COL_W'(hi_x);
        box_y1   = (hi_y > 11'(ht - 10'd1)) ? ROW_W'(ht - 10'd1) : ROW_W'(hi_y);
    end

    // |pixel - centre|, always below 2^24 inside the box
    always_comb
    begin
        xpos   = 26'({x_reg, 16'b0});
        ypos   = 26'({y_reg, 16'b0});
        dx_abs = (xpos >= cx_reg) ? MUL_W'(xpos - cx_reg) : MUL_W'(cx_reg - xpos);
        dy_abs = (ypos >= cy_reg) ? MUL_W'(ypos - cy_reg) : MUL_W'(cy_reg - ypos);
    end

    // smooth-min merge
    always_comb
    begin
        old      = mem_rdata;
        dist_q8  = 18'((ROOT_W'(sq_rsp.root) + ROOT_W'(128)) >> 8);
        cur      = $signed({6'b0, dist_q8}) - $signed({4'b0, rw_reg});
        diff     = 25'(old) - 25'(cur);
        diff_abs = (diff < 0) ? 25'(-diff) : 25'(diff);
        h_val    = (diff_abs >= 25'd1024) ? 11'd0 : 11'(25'd1024 - diff_abs);
        hq       = 11'((prod[20:0] + 21'd512) >> 10);
        nv       = 25'(mn_reg) - $signed({14'b0, hq});
        nv_sat   = (nv < 25'(FIELD_MIN)) ? FIELD_MIN : FIELD_W'(nv);
        rd_far   = (32'(rcol_reg) >= MAX_WIDTH) || (32'(rrow_reg) >= MAX_HEIGHT);
        fin_go   = !out_valid_reg || cell_out.ready;
    end

    // sequencer, multiplier operands, memory and root requests
    always_comb
    begin
        state_next     = state_reg;
        mul_a          = '0;
        mul_b          = '0;
        mem_req.we     = 1'b0;
        mem_req.waddr  = {y_reg, x_reg};
        mem_req.wdata  = nv_sat;
        mem_req.re     = 1'b0;
        mem_req.raddr  = {y_reg, x_reg};
        sq_req.start   = 1'b0;
        sq_req.operand = SQ_W'(prod) + SQ_W'(dy2_reg);
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    case (action_t'(fiber_in.action))
                        ACT_CLEAR: state_next = ST_CLEAR;
                        ACT_SPLAT: state_next = (fiber_in.fiber_weight < thresh_reg) ?
                                                ST_FIN : ST_CX;
                        ACT_READ:  state_next = ST_RD;
                        default:   state_next = ST_FIN;
                    endcase
                end
            end
            ST_CLEAR:
            begin
                mem_req.we    = 1'b1;
                mem_req.waddr = clr_cnt_reg;
                mem_req.wdata = FAR_VALUE;
                if (clr_cnt_reg == ADDR_W'(CELLS - 1))
                    state_next = clr_item_reg ? ST_FIN : ST_IDLE;
            end
            ST_CX:
            begin
                mul_a      = MUL_W'(fx_reg ^ 16'h8000);
                mul_b      = MUL_W'(wd);
                state_next = ST_CY;
            end
            ST_CY:
            begin
                mul_a      = MUL_W'(fy_reg ^ 16'h8000);
                mul_b      = MUL_W'(ht);
                state_next = ST_RW;
            end
            ST_RW:
            begin
                mul_a      = MUL_W'(radius_reg);
                mul_b      = MUL_W'(w_reg);
                state_next = ST_BOX;
            end
            ST_BOX: state_next = ST_DY;
            ST_DY:
            begin
                mul_a      = dy_abs;
                mul_b      = dy_abs;
                state_next = ST_DY2;
            end
            ST_DY2: state_next = ST_DX;
            ST_DX:
            begin
                mul_a      = dx_abs;
                mul_b      = dx_abs;
                state_next = ST_SQ;
            end
            ST_SQ:
            begin
                sq_req.start = 1'b1;
                mem_req.re   = 1'b1;
                state_next   = ST_SQW;
            end
            ST_SQW:
            begin
                if (sq_rsp.done)
                    state_next = ST_M1;
            end
            ST_M1:
            begin
                mul_a      = MUL_W'(h_val);
                mul_b      = MUL_W'(h_val);
                state_next = ST_M2;
            end
            ST_M2:
            begin
                mem_req.we = 1'b1;
                if (x_reg != x1_reg)
                    state_next = ST_DX;
                else if (y_reg != y1_reg)
                    state_next = ST_DY;
                else
                    state_next = ST_FIN;
            end
            ST_RD:
            begin
                mem_req.re    = 1'b1;
                mem_req.raddr = {ROW_W'(rrow_reg), COL_W'(rcol_reg)};
                state_next    = ST_RD2;
            end
            ST_RD2: state_next = ST_FIN;
            ST_FIN:
            begin
                if (fin_go)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_CLEAR;
        else
            state_reg <= state_next;
    end

    // control: config, clear sweep, output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= 10'd512;
            height_reg    <= 10'd512;
            radius_reg    <= 7'd12;
            thresh_reg    <= 16'd41;
            clr_cnt_reg   <= '0;
            clr_item_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg.valid)
            begin
                case (cfg_idx_t'(cfg.index))
                    REG_WIDTH:  width_reg  <= cfg.data[9:0];
                    REG_HEIGHT: height_reg <= cfg.data[9:0];
                    REG_RADIUS: radius_reg <= cfg.data[6:0];
                    REG_THRESH: thresh_reg <= cfg.data;
                    default: ;
                endcase
            end
            if (state_reg == ST_CLEAR)
                clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (in_acc)
                clr_item_reg <= 1'b1;
            if (cell_out.valid && cell_out.ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_FIN && fin_go)
                out_valid_reg <= 1'b1;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            act_reg       <= fiber_in.action;
            fx_reg        <= fiber_in.fiber_x;
            fy_reg        <= fiber_in.fiber_y;
            w_reg         <= fiber_in.fiber_weight;
            rcol_reg      <= fiber_in.read_col;
            rrow_reg      <= fiber_in.read_row;
            res_value_reg <= '0;
            res_skip_reg  <= (action_t'(fiber_in.action) == ACT_SPLAT) &&
                             (fiber_in.fiber_weight < thresh_reg);
        end
        case (state_reg)
            ST_CY:  cx_reg <= prod[25:0];
            ST_RW:  cy_reg <= prod[25:0];
            ST_BOX:
            begin
                rw_reg <= 20'((24'(prod[22:0]) + 24'd8) >> 4);
                x0_reg <= box_x0;
                x1_reg <= box_x1;
                y1_reg <= box_y1;
                x_reg  <= box_x0;
                y_reg  <= box_y0;
            end
            ST_DY2: dy2_reg <= prod;
            ST_M1:  mn_reg <= (old < cur) ? old : cur;
            ST_M2:
            begin
                if (x_reg != x1_reg)
                begin
                    x_reg <= x_reg + 1'b1;
                end
                else
                begin
                    x_reg <= x0_reg;
                    y_reg <= y_reg + 1'b1;
                end
            end
            ST_RD2:
            begin
                if (action_t'(act_reg) == ACT_READ)
                    res_value_reg <= rd_far ? FAR_VALUE : mem_rdata;
            end
            ST_FIN:
            begin
                if (fin_go)
                begin
                    out_value_reg <= res_value_reg;
                    out_skip_reg  <= res_skip_reg;
                end
            end
            default: ;
        endcase
    end

    assign cell_out.valid         = out_valid_reg;
    assign cell_out.cell_value    = out_value_reg;
    assign cell_out.fiber_skipped = out_skip_reg;

endmodule

[rtl/sdfc_mul.sv]
module sdfc_mul
    import sdfc_pkg::*;
(
    input  logic              clk,
    input  logic [MUL_W-1:0]  a,
    input  logic [MUL_W-1:0]  b,
    output logic [PROD_W-1:0] prod
);

    logic [PROD_W-1:0] prod_reg;

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign prod = prod_reg;

endmodule

[rtl/sdfc_isqrt.sv]
module sdfc_isqrt
    import sdfc_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  sqrt_req_t req,
    output sqrt_rsp_t rsp
);

    logic [SQ_W-1:0] v_reg, v_next;
    logic [SQ_W-1:0] res_reg, res_next;
    logic [SQ_W-1:0] bit_reg, bit_next;
    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [SQ_W-1:0] trial;

    // one result bit per cycle, highest even weight first
    always_comb
    begin
        v_next    = v_reg;
        res_next  = res_reg;
        bit_next  = bit_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        trial     = res_reg + bit_reg;
        if (req.start)
        begin
            v_next    = req.operand;
            res_next  = '0;
            bit_next  = SQ_W'(1) << (SQ_W - 2);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (v_reg >= trial)
            begin
                v_next   = v_reg - trial;
                res_next = (res_reg >> 1) + bit_reg;
            end
            else
            begin
                res_next = res_reg >> 1;
            end
            bit_next = bit_reg >> 2;
            if (bit_reg[0])
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg   <= v_next;
        res_reg <= res_next;
        bit_reg <= bit_next;
    end

    assign rsp.done = done_reg;
    assign rsp.root = res_reg[ROOT_W-1:0];

endmodule

[rtl/sdfc_field_mem.sv]
module sdfc_field_mem
    import sdfc_pkg::*;
(
    input  logic                      clk,
    input  mem_req_t                  req,
    output logic signed [FIELD_W-1:0] rdata
);

    logic signed [FIELD_W-1:0] mem [CELLS];
    logic signed [FIELD_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (req.we)
        begin
            mem[req.waddr] <= req.wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.re)
        begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sdfc_checker.sv]
module sdfc_checker
    import sdfc_pkg::*;
(
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_ready,
    input logic                      out_valid,
    input logic                      out_ready,
    input logic signed [FIELD_W-1:0] out_value
);

    // result held while the receiver stalls
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_value))
        else $error("result dropped or changed under stall");

    // one request at a time
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    // a new result only appears after a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result without work");

endmodule

bind sdf_circle_splat_field sdfc_checker u_sdfc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (fiber_in.valid),
    .in_ready  (fiber_in.ready),
    .out_valid (cell_out.valid),
    .out_ready (cell_out.ready),
    .out_value (cell_out.cell_value)
);
